// ===== rtl/lps_pkg.sv =====
// lps_pkg: shared constants, codes and types for the linear probe seen set.
// No dependencies; imported by linear_probe_seen_set.
`default_nettype none

package lps_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int SLOT_W      = 6;   // slot and slot_index field width
    localparam int KEY_W       = 64;
    localparam int CNT_W       = 7;   // fill count, table size, fill limit
    localparam int CFG_IDX_W   = 2;
    localparam int MOD_BITS    = 8;   // key bits folded into the remainder per cycle
    localparam int MOD_STEPS   = KEY_W / MOD_BITS;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

    localparam logic [CNT_W-1:0] TABLE_SIZE_RST = 7'd16;
    localparam logic [CNT_W-1:0] FILL_LIMIT_RST = 7'd12;
    localparam logic [CNT_W-1:0] DEPTH_CNT      = CNT_W'(TABLE_DEPTH);

    localparam logic [1:0] FUNC_CONTAINS = 2'd0;
    localparam logic [1:0] FUNC_ADD      = 2'd1;
    localparam logic [1:0] FUNC_REHASH   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOT_OCC = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_LIMIT = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REH_RD,
        S_REH_KEY,
        S_MOD,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_FINISH,
        S_DONE
    } lps_state_t;

endpackage

`default_nettype wire

// ===== rtl/lps_ram.sv =====
// lps_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/linear_probe_seen_set.sv =====
// linear_probe_seen_set: contains/add take the key modulo, then probe 1 to table size slots;
// key zero, func 3 and a refused rehash go straight to the result. The key modulo runs in the
// shared remainder unit, a key byte at a time; each probe reads the key RAM, then checks the
// slot. One item in flight, next input taken once the result sits in the output register. Reset
// (async, rst_n low) marks all slots empty, clears the fill count and loads table size 16, fill
// limit 12; the key RAM is not cleared.
`default_nettype none

module linear_probe_seen_set
    import lps_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           func,
    input  wire logic [KEY_W-1:0]     key,
    input  wire logic [SLOT_W-1:0]    slot_index,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      found,
    output logic [1:0]                status,
    output logic [SLOT_W-1:0]         slot,
    output logic [CNT_W-1:0]          fill_count,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_data
);

    // ------------------------------------------------------------------
    // Control and configuration state
    // ------------------------------------------------------------------
    lps_state_t state_reg, state_next;

    logic [CNT_W-1:0]       table_size_reg;
    logic [CNT_W-1:0]       fill_limit_reg;
    logic [CNT_W-1:0]       occ_reg;
    logic [TABLE_DEPTH-1:0] full_reg;     // slot holds a live key
    logic [TABLE_DEPTH-1:0] tomb_reg;     // slot is a tombstone
    logic                   out_valid_reg;

    // Item under work
    logic [1:0]             func_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [SLOT_W-1:0]      idx_reg;

    // Modulo unit
    logic [SLOT_W-1:0]      rem_reg;
    logic [MOD_CNT_W-1:0]   mod_cnt_reg;
    logic [SLOT_W-1:0]      mod_rem;

    // Probe sequencer
    logic [SLOT_W-1:0]      p_reg;
    logic [CNT_W-1:0]       probe_cnt_reg;
    logic                   hit_reg;
    logic [SLOT_W-1:0]      hit_slot_reg;
    logic                   free_vld_reg;
    logic [SLOT_W-1:0]      free_slot_reg;

    // Result staged for the output register
    logic                   res_found_reg;
    logic [1:0]             res_status_reg;
    logic [SLOT_W-1:0]      res_slot_reg;

    // Output register payload
    logic                   out_found_reg;
    logic [1:0]             out_status_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [CNT_W-1:0]       out_fill_reg;

    // Key RAM
    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    logic [SLOT_W-1:0]      ram_raddr;
    logic [KEY_W-1:0]       ram_rdata;

    // ------------------------------------------------------------------
    // Derived conditions
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  n_eff;
    logic              in_fire;
    logic              cfg_fire;
    logic              out_free;
    logic              reh_ok;
    logic              cur_full;
    logic              cur_empty;
    logic              cur_match;
    logic              probe_last;
    logic              probe_end;
    logic [SLOT_W-1:0] p_adv;
    logic              add_ok;

    // Out-of-range table sizes: zero acts as one slot, above depth saturates.
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (table_size_reg > DEPTH_CNT)
        begin
            n_eff = DEPTH_CNT;
        end
        else
        begin
            n_eff = table_size_reg;
        end
    end

    assign in_fire  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;   // writes must arrive only while idle (user's duty); cfg_ready is tied high
    assign cfg_fire = cfg_valid && cfg_ready;
    assign out_free = !out_valid_reg || !out_stall;

    // Rehash needs an in-range, occupied slot.
    assign reh_ok = ({1'b0, slot_index} < n_eff) && full_reg[slot_index];

    // One probe step: marks from flops, key from the RAM read issued last cycle.
    // A rehash re-add never matches; it only looks for the first free slot.
    assign cur_full   = full_reg[p_reg];
    assign cur_empty  = !full_reg[p_reg] && !tomb_reg[p_reg];
    assign cur_match  = cur_full && (func_reg != FUNC_REHASH) && (ram_rdata == key_reg);
    assign probe_last = (probe_cnt_reg + CNT_W'(1)) == n_eff;
    assign probe_end  = cur_empty || cur_match || probe_last;
    assign p_adv      = (({1'b0, p_reg} + CNT_W'(1)) == n_eff) ? '0 : p_reg + SLOT_W'(1);

    assign add_ok = !hit_reg && (occ_reg < fill_limit_reg) && free_vld_reg;

    // Shared remainder unit: folds one key byte, msb first, into key mod n.
    always_comb
    begin
        logic [MOD_BITS-1:0] kbyte;
        logic [CNT_W-1:0]    t;
        logic [SLOT_W-1:0]   r;
        kbyte = key_reg[{~mod_cnt_reg, 3'b000} +: MOD_BITS];
        r     = rem_reg;
        for (int j = 0; j < MOD_BITS; j++)
        begin
            t = {r, kbyte[MOD_BITS-1-j]};
            if (t >= n_eff)
            begin
                t = t - n_eff;
            end
            r = t[SLOT_W-1:0];
        end
        mod_rem = r;
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (func)
                        FUNC_CONTAINS, FUNC_ADD:
                            state_next = (key == '0) ? S_DONE : S_MOD;
                        FUNC_REHASH:
                            state_next = reh_ok ? S_REH_RD : S_DONE;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_REH_RD:    state_next = S_REH_KEY;
            S_REH_KEY:   state_next = S_MOD;
            S_MOD:
            begin
                if (mod_cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
                begin
                    state_next = S_PROBE_RD;
                end
            end
            S_PROBE_RD:  state_next = S_PROBE_CHK;
            S_PROBE_CHK: state_next = probe_end ? S_FINISH : S_PROBE_RD;
            S_FINISH:    state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        ram_raddr = (state_reg == S_REH_RD) ? idx_reg : p_reg;
        ram_waddr = free_slot_reg;
        ram_we    = (state_reg == S_FINISH) &&
                    ((func_reg == FUNC_REHASH) || ((func_reg == FUNC_ADD) && add_ok));
    end

    lps_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            table_size_reg <= TABLE_SIZE_RST;
            fill_limit_reg <= FILL_LIMIT_RST;
            occ_reg        <= '0;
            full_reg       <= '0;
            tomb_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_fire)
            begin
                case (cfg_index)
                    CFG_TABLE_SIZE: table_size_reg <= cfg_data;
                    CFG_FILL_LIMIT: fill_limit_reg <= cfg_data;
                    default:        ;
                endcase
            end

            // tombstone the slot being rehashed
            if (state_reg == S_REH_RD)
            begin
                full_reg[idx_reg] <= 1'b0;
                tomb_reg[idx_reg] <= 1'b1;
                occ_reg           <= occ_reg - CNT_W'(1);
            end

            if (ram_we)
            begin
                full_reg[free_slot_reg] <= 1'b1;
                tomb_reg[free_slot_reg] <= 1'b0;
                occ_reg                 <= occ_reg + CNT_W'(1);
            end

            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    func_reg       <= func;
                    key_reg        <= key;
                    idx_reg        <= slot_index;
                    rem_reg        <= '0;
                    mod_cnt_reg    <= '0;
                    res_found_reg  <= 1'b0;
                    res_slot_reg   <= '0;
                    res_status_reg <= ST_OK;
                    if ((func == FUNC_ADD) && (key == '0))
                    begin
                        res_status_reg <= ST_DUP;
                    end
                    else if ((func == FUNC_REHASH) && !reh_ok)
                    begin
                        res_status_reg <= ST_NOT_OCC;
                    end
                end
            end
            S_REH_KEY:
            begin
                key_reg <= ram_rdata;
            end
            S_MOD:
            begin
                rem_reg     <= mod_rem;
                mod_cnt_reg <= mod_cnt_reg + MOD_CNT_W'(1);
                if (mod_cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
                begin
                    p_reg         <= mod_rem;
                    probe_cnt_reg <= '0;
                    hit_reg       <= 1'b0;
                    free_vld_reg  <= 1'b0;
                end
            end
            S_PROBE_CHK:
            begin
                // first empty or tombstone slot from home, kept for an insert
                if (!free_vld_reg && !cur_full)
                begin
                    free_vld_reg  <= 1'b1;
                    free_slot_reg <= p_reg;
                end
                if (cur_match)
                begin
                    hit_reg      <= 1'b1;
                    hit_slot_reg <= p_reg;
                end
                p_reg         <= p_adv;
                probe_cnt_reg <= probe_cnt_reg + CNT_W'(1);
            end
            S_FINISH:
            begin
                case (func_reg)
                    FUNC_CONTAINS:
                    begin
                        res_found_reg <= hit_reg;
                        res_slot_reg  <= hit_reg ? hit_slot_reg : '0;
                    end
                    FUNC_ADD:
                    begin
                        if (hit_reg)
                        begin
                            res_status_reg <= ST_DUP;
                            res_slot_reg   <= hit_slot_reg;
                        end
                        else if (add_ok)
                        begin
                            res_slot_reg <= free_slot_reg;
                        end
                        else
                        begin
                            res_status_reg <= ST_FULL;
                        end
                    end
                    FUNC_REHASH:
                    begin
                        res_slot_reg <= free_slot_reg;
                    end
                    default: ;
                endcase
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_found_reg  <= res_found_reg;
                    out_status_reg <= res_status_reg;
                    out_slot_reg   <= res_slot_reg;
                    out_fill_reg   <= occ_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign found      = out_found_reg;
    assign status     = out_status_reg;
    assign slot       = out_slot_reg;
    assign fill_count = out_fill_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // fill count tracks the live marks exactly
    a_fill_matches_marks: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(full_reg) == occ_reg)
        else $error("fill count out of step with occupied marks");

    // a slot is never both live and tombstoned
    a_marks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg & tomb_reg) == '0)
        else $error("slot marked both occupied and tombstone");

    // probing stays inside the effective table
    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE_CHK) |-> ({1'b0, p_reg} < n_eff))
        else $error("probe pointer beyond table size");

    // a key write always lands on a free slot
    a_write_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (free_vld_reg && !full_reg[free_slot_reg]))
        else $error("key written over a live slot");

endmodule

`default_nettype wire
